/* design/assert_macros.svh */
// Assertion macros for the top level of the ordered list block.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in every cycle outside reset.
`define OLAD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define OLAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/olad_pkg.sv */
// Shared constants, codes and controller/datapath structs of the ordered list.
// Depends on nothing; olad_if, olad_dp, olad_ctrl and the top level import it.
package olad_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [1:0]              func_type;
   typedef logic [1:0]              status_type;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [POS_W-1:0]        position_type;
   typedef logic [CNT_W-1:0]        count_type;

   localparam func_type FUNC_APPEND   = 2'd0;
   localparam func_type FUNC_DELETE   = 2'd1;
   localparam func_type FUNC_TRAVERSE = 2'd2;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_EMPTY  = 2'd1;
   localparam status_type STATUS_BADPOS = 2'd2;
   localparam status_type STATUS_FULL   = 2'd3;

   typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_POS, IDX_INC} idx_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_type;
   typedef enum logic [1:0] {KIND_ERR, KIND_APPEND, KIND_DELETE, KIND_TRAV} rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         grab;
      idx_op_type   idx_op;
      cnt_op_type   cnt_op;
      logic         ram_we;
      logic         wr_shift;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
      status_type   rsp_status;
   } olad_cmd_type;

   typedef struct packed {
      func_type func;
      logic     empty;
      logic     full;
      logic     pos_bad;
      logic     shift_done;
      logic     trav_last;
      logic     slot_free;
   } olad_sts_type;

endpackage

/* design/olad_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on olad_pkg for the payload types.
interface olad_req_if;
   import olad_pkg::*;
   logic         valid;
   logic         ready;
   func_type     func;
   value_type    value;
   position_type position;

   modport source (output valid, func, value, position, input ready);
   modport sink (input valid, func, value, position, output ready);
endinterface

interface olad_rsp_if;
   import olad_pkg::*;
   logic         valid;
   logic         ready;
   status_type   status;
   value_type    item_value;
   position_type item_position;
   position_type entry_count;
   logic         last;

   modport source (output valid, status, item_value, item_position, entry_count, last,
                   input ready);
   modport sink (input valid, status, item_value, item_position, entry_count, last,
                 output ready);
endinterface

/* design/olad_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module olad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* design/olad_dp.sv */
// Datapath of the ordered list: entry RAM, fill count, walk index,
// captured request and the response register. Depends on olad_pkg, olad_ram.
module olad_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  olad_pkg::func_type     req_func,
   input  olad_pkg::value_type    req_value,
   input  olad_pkg::position_type req_position,
   input  olad_pkg::olad_cmd_type cmd,
   output olad_pkg::olad_sts_type sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output olad_pkg::status_type   rsp_status,
   output olad_pkg::value_type    rsp_item_value,
   output olad_pkg::position_type rsp_item_position,
   output olad_pkg::position_type rsp_entry_count,
   output logic                  rsp_last
);
   import olad_pkg::*;

   func_type     func_ff;
   value_type    hold_ff;
   position_type pos_ff;
   count_type    count_ff, count_in;
   count_type    idx_ff, idx_in;
   logic         rsp_valid_ff;
   status_type   status_ff;
   value_type    value_ff, value_in;
   position_type rpos_ff, rpos_in;
   position_type ecount_ff;
   logic         last_ff, last_in;

   logic [VAL_W-1:0] rd_data;
   logic [IDX_W-1:0] wr_addr;
   value_type        wr_data;

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_ZERO: idx_in = '0;
         IDX_POS:  idx_in = CNT_W'(pos_ff - POS_W'(1));
         IDX_INC:  idx_in = idx_ff + CNT_W'(1);
         default:  idx_in = idx_ff;
      endcase
      case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
   end

   // An append lands behind the tail; a shift moves entry idx down one place.
   assign wr_addr = cmd.wr_shift ? IDX_W'(idx_ff - CNT_W'(1)) : count_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_shift ? value_type'(rd_data) : hold_ff;

   // The read address follows the next index, so the data lines up with idx_ff.
   olad_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      last_in = 1'b1;
      case (cmd.rsp_kind)
         KIND_ERR: begin
            value_in = '0;
            rpos_in  = '0;
         end
         KIND_APPEND: begin
            value_in = hold_ff;
            rpos_in  = POS_W'(count_in);
         end
         KIND_DELETE: begin
            value_in = hold_ff;
            rpos_in  = pos_ff;
         end
         KIND_TRAV: begin
            value_in = value_type'(rd_data);
            rpos_in  = POS_W'(idx_ff + CNT_W'(1));
            last_in  = sts.trav_last;
         end
         default: begin
            value_in = '0;
            rpos_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      idx_ff <= idx_in;
      if (cmd.capture) begin
         func_ff <= req_func;
         hold_ff <= req_value;
         pos_ff  <= req_position;
      end else if (cmd.grab) begin
         hold_ff <= value_type'(rd_data);
      end
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         value_ff  <= value_in;
         rpos_ff   <= rpos_in;
         ecount_ff <= POS_W'(count_in);
         last_ff   <= last_in;
      end
   end

   always_comb begin
      sts.func       = func_ff;
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == CNT_W'(DEPTH));
      sts.pos_bad    = (pos_ff == '0) || (CMP_W'(pos_ff) > CMP_W'(count_ff));
      sts.shift_done = (idx_ff == count_ff);
      sts.trav_last  = ((idx_ff + CNT_W'(1)) == count_ff);
      sts.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_item_value    = value_ff;
   assign rsp_item_position = rpos_ff;
   assign rsp_entry_count   = ecount_ff;
   assign rsp_last          = last_ff;
endmodule

/* design/olad_ctrl.sv */
// Controller of the ordered list: sequences append, delete and traverse.
// Depends on olad_pkg for the command and status structs.
module olad_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olad_pkg::olad_sts_type sts,
   output olad_pkg::olad_cmd_type cmd
);
   import olad_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DEL_GRAB, S_DEL_SHIFT, S_TRAV} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.grab       = 1'b0;
      cmd.idx_op     = IDX_HOLD;
      cmd.cnt_op     = CNT_HOLD;
      cmd.ram_we     = 1'b0;
      cmd.wr_shift   = 1'b0;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_kind   = KIND_ERR;
      cmd.rsp_status = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.func)
               FUNC_APPEND: begin
                  if (sts.slot_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                     if (sts.full) begin
                        cmd.rsp_status = STATUS_FULL;
                     end else begin
                        cmd.ram_we   = 1'b1;
                        cmd.cnt_op   = CNT_INC;
                        cmd.rsp_kind = KIND_APPEND;
                     end
                  end
               end
               FUNC_DELETE: begin
                  if (sts.empty || sts.pos_bad) begin
                     if (sts.slot_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = sts.empty ? STATUS_EMPTY : STATUS_BADPOS;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.idx_op = IDX_POS;
                     state_in   = S_DEL_GRAB;
                  end
               end
               FUNC_TRAVERSE: begin
                  if (sts.empty) begin
                     if (sts.slot_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_TRAV;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DEL_GRAB: begin
            // The removed entry is on the read port now; keep it for the response.
            cmd.grab   = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_DEL_SHIFT;
         end
         S_DEL_SHIFT: begin
            if (!sts.shift_done) begin
               cmd.ram_we   = 1'b1;
               cmd.wr_shift = 1'b1;
               cmd.idx_op   = IDX_INC;
            end else if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = KIND_DELETE;
               cmd.cnt_op   = CNT_DEC;
               state_in     = S_IDLE;
            end
         end
         S_TRAV: begin
            // While the response register is full the index holds, and so does the read.
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = KIND_TRAV;
               if (sts.trav_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = IDX_INC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

/* design/ordered_list_append_delete.sv */
// Top level of the bounded ordered list with append, delete and traverse.
// Depends on olad_pkg, olad_if, olad_ctrl, olad_dp and assert_macros.svh.
//
//   channel   direction  carries
//   req_ch    in         func, value, position
//   rsp_ch    out        status, item_value, item_position, entry_count, last
//
// One item at a time: req_ch.ready is high only while the controller is idle.
// Delete at position p moves each entry behind it down one place, one shift per cycle,
// through the single RAM write port; traverse returns the entries in order.
// Results wait in an output register, so a stalled rsp_ch holds the walk in place.
// Synchronous reset empties the list at once; stored entries are not cleared.
`include "assert_macros.svh"

module ordered_list_append_delete (
   input logic         clock,
   input logic         reset,
   olad_req_if.sink    req_ch,
   olad_rsp_if.source  rsp_ch
);
   import olad_pkg::*;

   olad_cmd_type cmd;
   olad_sts_type sts;

   olad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   olad_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_ch.func),
      .req_value         (req_ch.value),
      .req_position      (req_ch.position),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_item_value    (rsp_ch.item_value),
      .rsp_item_position (rsp_ch.item_position),
      .rsp_entry_count   (rsp_ch.entry_count),
      .rsp_last          (rsp_ch.last)
   );

   // The block takes a new item only after finishing the one before.
   `OLAD_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready)

   // Error results are single, final and carry no entry.
   `OLAD_ASSERT(a_error_result,
      !(rsp_ch.valid && rsp_ch.status != STATUS_OK) ||
      (rsp_ch.last && rsp_ch.item_position == '0 && rsp_ch.item_value == '0))

   // A good result names a real position, at most one past the count after a delete.
   `OLAD_ASSERT(a_ok_position,
      !(rsp_ch.valid && rsp_ch.status == STATUS_OK) ||
      (rsp_ch.item_position != '0 &&
       6'(rsp_ch.item_position) <= 6'(rsp_ch.entry_count) + 6'd1))

   // Only traversal leaves a result unmarked as final, and only with good status.
   `OLAD_ASSERT(a_nonfinal_ok, !(rsp_ch.valid && !rsp_ch.last) || (rsp_ch.status == STATUS_OK))
endmodule
